// ===== src/pbs_pkg.sv =====
// Shared types and constants of the power button sequencer.
package pbs_pkg;

    // Configuration register width and index width of the write channel
    localparam int CFG_W = 16;
    localparam int IDX_W = 8;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_ON_HOLD     = 8'd0;
    localparam logic [IDX_W-1:0] CFG_OFF_HOLD    = 8'd1;
    localparam logic [IDX_W-1:0] CFG_BLINK       = 8'd2;
    localparam logic [IDX_W-1:0] CFG_RESTART_OFF = 8'd3;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_ON_HOLD     = 16'd1500;
    localparam logic [CFG_W-1:0] RST_OFF_HOLD    = 16'd4000;
    localparam logic [CFG_W-1:0] RST_BLINK       = 16'd250;
    localparam logic [CFG_W-1:0] RST_RESTART_OFF = 16'd1000;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HOLD    = 2'd1,
        PH_WARM    = 2'd2,
        PH_RESTART = 2'd3
    } t_phase;

    typedef struct packed {
        logic [CFG_W-1:0] on_hold_ticks;
        logic [CFG_W-1:0] off_hold_ticks;
        logic [CFG_W-1:0] blink_period;
        logic [CFG_W-1:0] restart_off_ticks;
    } t_cfg;

    typedef struct packed {
        logic key_down;
        logic under_temp;
        logic reset_request;
    } t_tick;

    typedef struct packed {
        logic power_enable;
        logic power_led;
        logic heater;
        logic thermal_led;
    } t_result;

endpackage

// ===== src/pbs_if.sv =====
// Handshake channel interfaces: tick items, result items and configuration writes.
interface pbs_in_if;
    logic valid;
    logic ready;
    logic key_down;
    logic under_temp;
    logic reset_request;

    modport source (output valid, output key_down, output under_temp,
                    output reset_request, input ready);
    modport sink   (input valid, input key_down, input under_temp,
                    input reset_request, output ready);
endinterface

interface pbs_out_if;
    logic valid;
    logic ready;
    logic power_enable;
    logic power_led;
    logic heater;
    logic thermal_led;

    modport source (output valid, output power_enable, output power_led,
                    output heater, output thermal_led, input ready);
    modport sink   (input valid, input power_enable, input power_led,
                    input heater, input thermal_led, output ready);
endinterface

interface pbs_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/pbs_core.sv =====
// Sequencer state and the per-tick update of phase, counters and result bits.
module pbs_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  pbs_pkg::t_tick   i_tick,
    input  pbs_pkg::t_cfg    i_cfg,
    output pbs_pkg::t_result o_result
);
    import pbs_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
    localparam int BLK_W = (COUNT_WIDTH + 1 > CFG_W) ? COUNT_WIDTH + 1 : CFG_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    t_phase                 r_phase, n_phase;
    logic                   r_was_on, n_was_on;
    logic                   r_last_key, n_last_key;
    logic [COUNT_WIDTH-1:0] r_hold, n_hold;
    logic [COUNT_WIDTH-1:0] r_blink, n_blink;
    logic [COUNT_WIDTH-1:0] r_restart, n_restart;

    logic                   lit;
    logic [COUNT_WIDTH:0]   blink_inc;
    logic [CMP_W-1:0]       hold_thr;

    // Lit half of the blink period, taken from the count before this tick
    assign lit = BLK_W'(r_blink) < BLK_W'(i_cfg.blink_period >> 1);

    assign hold_thr = r_was_on ? CMP_W'(i_cfg.off_hold_ticks)
                               : CMP_W'(i_cfg.on_hold_ticks);

    // Next state: key logic first, then the restart request
    always_comb begin
        logic do_hold;
        logic do_start;
        do_hold    = 1'b0;
        do_start   = 1'b0;
        n_phase    = r_phase;
        n_was_on   = r_was_on;
        n_last_key = r_last_key;
        n_hold     = r_hold;
        n_restart  = r_restart;

        case (r_phase)
            PH_HOLD: begin
                if (i_tick.key_down) begin
                    n_hold  = (r_hold == CNT_MAX) ? r_hold : r_hold + 1'b1;
                    do_hold = 1'b1;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_WARM: begin
                if (!i_tick.under_temp) begin
                    n_phase  = PH_IDLE;
                    n_was_on = 1'b1;
                end
            end
            PH_RESTART: begin
                n_restart = (r_restart == CNT_MAX) ? r_restart : r_restart + 1'b1;
                do_start  = CMP_W'(n_restart) >= CMP_W'(i_cfg.restart_off_ticks);
            end
            default: begin
                n_phase    = PH_IDLE;
                n_last_key = i_tick.key_down;
                if (i_tick.key_down && !r_last_key) begin
                    n_phase = PH_HOLD;
                    n_hold  = '0;
                    do_hold = 1'b1;
                end
            end
        endcase

        // Fire the hold action once the count meets the threshold
        if (do_hold && CMP_W'(n_hold) >= hold_thr) begin
            if (r_was_on) begin
                n_was_on = 1'b0;
                n_phase  = PH_IDLE;
            end else begin
                do_start = 1'b1;
            end
        end

        if (do_start) begin
            if (i_tick.under_temp) begin
                n_phase = PH_WARM;
            end else begin
                n_phase  = PH_IDLE;
                n_was_on = 1'b1;
            end
        end

        // Restart request while on: drop power and start the off wait
        if (r_phase != PH_RESTART && n_phase == PH_IDLE && n_was_on &&
            i_tick.reset_request) begin
            n_was_on  = 1'b0;
            n_phase   = PH_RESTART;
            n_restart = '0;
            if (i_cfg.restart_off_ticks == '0) begin
                if (i_tick.under_temp) begin
                    n_phase = PH_WARM;
                end else begin
                    n_phase  = PH_IDLE;
                    n_was_on = 1'b1;
                end
            end
        end
    end

    // Free-running blink phase counter
    always_comb begin
        blink_inc = {1'b0, r_blink} + 1'b1;
        if (BLK_W'(blink_inc) >= BLK_W'(i_cfg.blink_period) || blink_inc[COUNT_WIDTH]) begin
            n_blink = '0;
        end else begin
            n_blink = blink_inc[COUNT_WIDTH-1:0];
        end
    end

    // Outputs from the state after this tick's update
    always_comb begin
        o_result.power_enable = n_was_on;
        o_result.power_led    = n_was_on;
        o_result.heater       = (n_phase == PH_WARM);
        o_result.thermal_led  = (n_phase == PH_WARM) && lit;
    end

    // Advance the state once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_was_on   <= 1'b0;
            r_last_key <= 1'b0;
            r_hold     <= '0;
            r_blink    <= '0;
            r_restart  <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_was_on   <= n_was_on;
            r_last_key <= n_last_key;
            r_hold     <= n_hold;
            r_blink    <= n_blink;
            r_restart  <= n_restart;
        end
    end

endmodule

// ===== src/power_button_sequencer.sv =====
// Top level of the power button sequencer: input stage, configuration and result register.
// One tick item in, one result item out, at up to one item per clock. An item is
// registered at the input, goes through the sequencer update and lands in the result
// register; the result register and input stage let a new tick be taken every clock
// while the downstream side keeps ready high. Configuration writes are taken at any
// time (ready is always high) and must only be made while no tick is in flight.
// The hold and restart counters are COUNT_WIDTH bits and saturate; thresholds beyond
// that never fire.
module power_button_sequencer #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pbs_in_if.sink    i_in,
    pbs_cfg_if.sink   i_cfg,
    pbs_out_if.source o_out
);
    import pbs_pkg::*;

    t_cfg    r_cfg;
    logic    r_s1_valid;
    t_tick   r_tick;
    logic    r_out_valid;
    t_result r_out;
    t_result result;
    logic    s1_go;

    assign s1_go      = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s1_go;
    assign i_cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.on_hold_ticks     <= RST_ON_HOLD;
            r_cfg.off_hold_ticks    <= RST_OFF_HOLD;
            r_cfg.blink_period      <= RST_BLINK;
            r_cfg.restart_off_ticks <= RST_RESTART_OFF;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ON_HOLD:     r_cfg.on_hold_ticks     <= i_cfg.data;
                CFG_OFF_HOLD:    r_cfg.off_hold_ticks    <= i_cfg.data;
                CFG_BLINK:       r_cfg.blink_period      <= i_cfg.data;
                CFG_RESTART_OFF: r_cfg.restart_off_ticks <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Input stage: hold the accepted tick until it moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_tick.key_down      <= i_in.key_down;
            r_tick.under_temp    <= i_in.under_temp;
            r_tick.reset_request <= i_in.reset_request;
        end
    end

    pbs_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (r_s1_valid && s1_go),
        .i_tick   (r_tick),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_valid) begin
            r_out <= result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.power_enable = r_out.power_enable;
    assign o_out.power_led    = r_out.power_led;
    assign o_out.heater       = r_out.heater;
    assign o_out.thermal_led  = r_out.thermal_led;

`ifndef SYNTHESIS
    // Heater runs only while the rail is still off
    a_heat_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.heater && r_out.power_enable))
        else $error("heater on with power enabled");

    // Thermal LED blinks only while warming
    a_led_heat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.thermal_led |-> r_out.heater)
        else $error("thermal LED lit outside warming");

    // A stalled result must not be dropped or replaced
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out))
        else $error("stalled result lost");
`endif

endmodule

// ===== bench/pbs_checker.sv =====
// Checker for the power button sequencer: tracks writes, predicts each result item, compares.
module pbs_checker
    import pbs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    pbs_in_if    in_ch,
    pbs_cfg_if   cfg_ch,
    pbs_out_if   out_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam int MAX_REPORTS = 10;

    // Mirror of the block's registers and sequencer state
    t_cfg             cfg;
    t_phase           phase;
    logic             was_on;
    logic             last_key;
    logic [CNT_W-1:0] hold_count;
    logic [CNT_W-1:0] blink_count;
    logic [CNT_W-1:0] restart_count;

    // Predicted outputs, oldest first
    t_result outputs_due[$];
    int      fails;
    int      checked;

    function automatic logic [CNT_W-1:0] sat_up(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // Power on, or go warming first while the board is cold
    function automatic void power_up(input logic cold);
        if (cold) begin
            phase = PH_WARM;
        end else begin
            phase  = PH_IDLE;
            was_on = 1'b1;
        end
    endfunction

    // Fire the on or off action once the key has been held long enough
    function automatic void judge_hold(input logic cold);
        logic [CNT_W-1:0] thr;
        thr = was_on ? cfg.off_hold_ticks : cfg.on_hold_ticks;
        if (hold_count >= thr) begin
            if (was_on) begin
                was_on = 1'b0;
                phase  = PH_IDLE;
            end else begin
                power_up(cold);
            end
        end
    endfunction

    // Advance the sequencer by one tick and return the outputs after the update
    function automatic t_result step_sequencer(input t_tick tk);
        t_result        res;
        logic           lit;
        logic           rise;
        t_phase         began;
        logic [CNT_W:0] nx;
        lit   = blink_count < (cfg.blink_period >> 1);
        began = phase;
        case (phase)
            PH_HOLD: begin
                if (tk.key_down) begin
                    hold_count = sat_up(hold_count);
                    judge_hold(tk.under_temp);
                end else begin
                    phase = PH_IDLE;
                end
            end
            PH_WARM: begin
                if (!tk.under_temp) begin
                    phase  = PH_IDLE;
                    was_on = 1'b1;
                end
            end
            PH_RESTART: begin
                restart_count = sat_up(restart_count);
                if (restart_count >= cfg.restart_off_ticks) power_up(tk.under_temp);
            end
            default: begin
                rise     = tk.key_down && !last_key;
                phase    = PH_IDLE;
                last_key = tk.key_down;
                if (rise) begin
                    phase      = PH_HOLD;
                    hold_count = '0;
                    judge_hold(tk.under_temp);
                end
            end
        endcase

        // Restart request while on: drop power and start the off wait
        if (began != PH_RESTART && phase == PH_IDLE && was_on && tk.reset_request) begin
            was_on        = 1'b0;
            phase         = PH_RESTART;
            restart_count = '0;
            if (restart_count >= cfg.restart_off_ticks) power_up(tk.under_temp);
        end

        res.power_enable = was_on;
        res.power_led    = was_on;
        res.heater       = (phase == PH_WARM);
        res.thermal_led  = (phase == PH_WARM) && lit;

        // Free-running blink phase, wraps at the period
        nx = {1'b0, blink_count} + 1'b1;
        if (nx >= {1'b0, cfg.blink_period}) nx = '0;
        blink_count = nx[CNT_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg = '{on_hold_ticks: RST_ON_HOLD, off_hold_ticks: RST_OFF_HOLD,
                    blink_period: RST_BLINK, restart_off_ticks: RST_RESTART_OFF};
            phase         = PH_IDLE;
            was_on        = 1'b0;
            last_key      = 1'b0;
            hold_count    = '0;
            blink_count   = '0;
            restart_count = '0;
            outputs_due.delete();
        end else begin
            // Compare an accepted result item against the oldest prediction
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.power_enable, out_ch.power_led, out_ch.heater,
                       out_ch.thermal_led};
                if (outputs_due.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t: unpredicted result pe/led/heat/tled=%b%b%b%b",
                                 $realtime, got.power_enable, got.power_led, got.heater,
                                 got.thermal_led);
                end else begin
                    want = outputs_due.pop_front();
                    checked++;
                    if (got.power_enable !== want.power_enable ||
                        got.power_led !== want.power_led ||
                        got.heater !== want.heater ||
                        got.thermal_led !== want.thermal_led) begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                            $display("%0t: result %0d pe/led/heat/tled exp %b%b%b%b got %b%b%b%b",
                                     $realtime, checked, want.power_enable, want.power_led,
                                     want.heater, want.thermal_led, got.power_enable,
                                     got.power_led, got.heater, got.thermal_led);
                    end
                end
            end

            // Track register writes
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_ON_HOLD:     cfg.on_hold_ticks     = cfg_ch.data;
                    CFG_OFF_HOLD:    cfg.off_hold_ticks    = cfg_ch.data;
                    CFG_BLINK:       cfg.blink_period      = cfg_ch.data;
                    CFG_RESTART_OFF: cfg.restart_off_ticks = cfg_ch.data;
                    default: ;
                endcase
            end

            // Predict the outputs of an accepted tick item
            if (in_ch.valid && in_ch.ready)
                outputs_due.push_back(step_sequencer({in_ch.key_down, in_ch.under_temp,
                                                      in_ch.reset_request}));
        end
        o_pending    <= outputs_due.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// ===== bench/tb_power_button_sequencer.sv =====
// Testbench top for the power button sequencer: clock, reset, tick and register stimulus, verdict.
module tb_power_button_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import pbs_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_STALL   = 300;
    localparam int RAND_PHASES  = 14;
    localparam int PHASE_TICKS  = 100;
    localparam logic [IDX_W-1:0] REG_SPARE = 8'hFC;
    localparam logic [CFG_W-1:0] MAX_CFG   = {CFG_W{1'b1}};

    logic i_clk = 1'b0;
    logic i_rst_n;

    int   cycle_count = 0;
    int   ticks_sent = 0;
    int   reg_writes = 0;
    int   settings_used = 0;
    int   stall_asks = 0;
    int   stalls_done = 0;
    int   burst_left = 0;
    int   on_cur;
    int   off_cur;
    logic cold_level = 1'b0;

    int   fail_count;
    int   pending;
    int   checked;

    pbs_in_if  in_ch ();
    pbs_out_if out_ch ();
    pbs_cfg_if cfg_ch ();

    power_button_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    pbs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .cfg_ch       (cfg_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results due", cycle_count, pending);
            $display("[power_button_sequencer] ERROR");
            $finish;
        end
    end

    // Mostly short idle gaps, a few long ones
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Mostly small register values, some medium, a few at the extremes
    function automatic logic [CFG_W-1:0] pick_count(input int lo, input int hi_small);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return CFG_W'($urandom_range(lo, hi_small));
        if (r < 93) return CFG_W'($urandom_range(lo, 40));
        return r[0] ? MAX_CFG : CFG_W'(lo);
    endfunction

    // Temperature level that flips now and then
    function automatic logic next_cold();
        if ($urandom_range(0, 11) == 0) cold_level = ~cold_level;
        return cold_level;
    endfunction

    function automatic logic pick_rreq();
        return $urandom_range(0, 9) == 0;
    endfunction

    // Offer one tick item after a random gap, hold until taken
    task automatic send_tick(input logic key, input logic cold, input logic rreq);
        int gap;
        gap = (burst_left > 0) ? 0 : pick_idle();
        if (burst_left > 0) burst_left--;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.key_down      <= key;
        in_ch.under_temp    <= cold;
        in_ch.reset_request <= rreq;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        ticks_sent++;
    endtask

    // Write one register; valid stays up for a following write
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        reg_writes++;
    endtask

    task automatic apply_setting(input logic [CFG_W-1:0] on_t, input logic [CFG_W-1:0] off_t,
                                 input logic [CFG_W-1:0] blink_t,
                                 input logic [CFG_W-1:0] restart_t);
        write_reg(CFG_ON_HOLD, on_t);
        write_reg(CFG_OFF_HOLD, off_t);
        write_reg(CFG_BLINK, blink_t);
        write_reg(CFG_RESTART_OFF, restart_t);
        cfg_ch.valid <= 1'b0;
        on_cur  = int'(on_t);
        off_cur = int'(off_t);
        settings_used++;
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Receiver: random stalls, long ready runs, and long hold-offs on request
    initial begin
        int run;
        int gap;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (stall_asks != stalls_done) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
                stalls_done++;
            end else begin
                run = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 8)
                                                   : $urandom_range(30, 150);
                out_ch.ready <= 1'b1;
                repeat (run) @(posedge i_clk);
                gap = pick_idle();
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int ph;
        int kind;
        int len;
        int thr;
        int phase_end;
        in_ch.valid         <= 1'b0;
        in_ch.key_down      <= 1'b0;
        in_ch.under_temp    <= 1'b0;
        in_ch.reset_request <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        i_rst_n             <= 1'b0;
        on_cur  = int'(RST_ON_HOLD);
        off_cur = int'(RST_OFF_HOLD);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: short presses and restart requests do nothing while off
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);

        // Smallest values; a write to an unused index must be ignored
        settle();
        write_reg(REG_SPARE, CFG_W'($urandom_range(0, int'(MAX_CFG))));
        apply_setting(16'd1, 16'd1, 16'd2, 16'd0);
        send_tick(1'b0, 1'b0, 1'b0);
        // Edge with restart request ignored in hold, then power on and instant restart
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b1);
        // Key still down: no edge; release, press again and power off
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        // Cold power on: warming with key and restart ignored, blink, then warm up
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        // Instant restart while cold goes back to warming
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);

        // Largest values: long blink period and a restart that never ends here
        settle();
        apply_setting(16'd1, MAX_CFG, MAX_CFG, MAX_CFG);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b0);

        // Random phases, each under a new setting
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            apply_setting(pick_count(1, 6), pick_count(1, 8), pick_count(2, 9),
                          pick_count(0, 6));
            if (ph == 2 || ph == 9) stall_asks++;
            phase_end = ticks_sent + PHASE_TICKS;
            while (ticks_sent < phase_end) begin
                kind = $urandom_range(0, 99);
                if ($urandom_range(0, 19) == 0) burst_left = 40;
                if (kind < 70) begin
                    // Press: release first so the press is an edge, hold around the threshold
                    thr = (on_cur > off_cur) ? on_cur : off_cur;
                    if (thr > 20) thr = 20;
                    len = $urandom_range(0, thr + 2);
                    if ($urandom_range(0, 4) == 0) cold_level = ~cold_level;
                    send_tick(1'b0, next_cold(), pick_rreq());
                    repeat (len + 1) send_tick(1'b1, next_cold(), pick_rreq());
                    repeat ($urandom_range(1, 3)) send_tick(1'b0, next_cold(), pick_rreq());
                end else if (kind < 85) begin
                    repeat ($urandom_range(1, 6)) send_tick(1'b0, next_cold(), pick_rreq());
                end else begin
                    repeat ($urandom_range(1, 6))
                        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
                end
            end
        end

        // Drain and let any stray result show up
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d tick items under %0d settings (%0d writes), %0d results compared",
                 ticks_sent, settings_used, reg_writes, checked);
        $display("Receiver held off %0d long stretches, %0d mismatches", stalls_done, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("[power_button_sequencer] OK");
        end else begin
            $display("[power_button_sequencer] ERROR");
        end
        $finish;
    end

endmodule
